// ===== design/tcpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch combo press classifier package
// Shared widths, codes and payload types of the touch combo press classifier.
// ----------------------------------------------------------------------------
package tcpc_pkg;

	localparam int NUM_PADS    = 8;
	localparam int TIME_BITS   = 32;
	localparam int PAD_W       = $clog2(NUM_PADS);
	localparam int TREE_LEAVES = 1 << $clog2(NUM_PADS);
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;

	typedef logic [PAD_W-1:0]     pad_t;
	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [NUM_PADS-1:0]  pad_vec_t;

	localparam logic MODE_RELEASE = 1'b0;
	localparam logic MODE_PRESS   = 1'b1;
	localparam logic EVENT_TOUCH  = 1'b0;
	localparam logic EVENT_COMBO  = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_COMBO_MASK    = 2'd0,
		CFG_LONG_HOLD_MS  = 2'd1,
		CFG_COMBO_EMIT_MS = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic                  mode;
		pad_t                  pad;
		time_t                 time_ms;
	} item_t;

	typedef struct packed {
		logic                  event_kind;
		pad_t                  pad_out;
		logic                  long_hold;
		time_t                 hold_ms;
	} result_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_wr_t;

	typedef struct packed {
		pad_vec_t              combo_mask;
		logic [15:0]           long_hold_ms;
		logic [15:0]           combo_emit_ms;
	} cfg_t;

endpackage

// ===== design/tcpc_in_if.sv =====
// ----------------------------------------------------------------------------
// Touch event channel
// Valid/ready channel that carries one pad press or release per transaction.
// ----------------------------------------------------------------------------
interface tcpc_in_if;

	logic              valid;
	logic              ready;
	logic              mode;
	tcpc_pkg::pad_t    pad;
	tcpc_pkg::time_t   time_ms;

	modport source (output valid, output mode, output pad, output time_ms, input ready);
	modport sink (input valid, input mode, input pad, input time_ms, output ready);

endinterface

// ===== design/tcpc_out_if.sv =====
// ----------------------------------------------------------------------------
// Classified event channel
// Valid/ready channel that carries one touch or combo event per transaction.
// ----------------------------------------------------------------------------
interface tcpc_out_if;

	logic              valid;
	logic              ready;
	logic              event_kind;
	tcpc_pkg::pad_t    pad_out;
	logic              long_hold;
	tcpc_pkg::time_t   hold_ms;

	modport source (output valid, output event_kind, output pad_out, output long_hold,
		output hold_ms, input ready);
	modport sink (input valid, input event_kind, input pad_out, input long_hold,
		input hold_ms, output ready);

endinterface

// ===== design/tcpc_in_stage.sv =====
// ----------------------------------------------------------------------------
// Input register
// Captures one touch transaction and holds it until the core takes it.
// ----------------------------------------------------------------------------
module tcpc_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	tcpc_in_if.sink         touch,
	input  logic            take,
	output logic            valid_s1,
	output tcpc_pkg::item_t item_s1
);

	assign touch.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (touch.ready) begin
			valid_s1 <= touch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (touch.valid && touch.ready) begin
			item_s1.mode    <= touch.mode;
			item_s1.pad     <= touch.pad;
			item_s1.time_ms <= touch.time_ms;
		end
	end

endmodule

// ===== design/tcpc_latest.sv =====
// ----------------------------------------------------------------------------
// Latest press search
// Finds the most recent press time among the active combo pads with a
// balanced compare tree over the wrapped ages.
// ----------------------------------------------------------------------------
module tcpc_latest (
	input  tcpc_pkg::time_t   now,
	input  tcpc_pkg::pad_vec_t cand,
	input  tcpc_pkg::time_t   times [tcpc_pkg::NUM_PADS],
	output tcpc_pkg::time_t   latest
);

	typedef struct packed {
		logic            vld;
		tcpc_pkg::time_t age;
		tcpc_pkg::time_t t;
	} node_t;

	node_t nodes [1:2*tcpc_pkg::TREE_LEAVES-1];

	always_comb begin
		for (int i = 0; i < tcpc_pkg::TREE_LEAVES; i++) begin
			if (i < tcpc_pkg::NUM_PADS) begin
				nodes[tcpc_pkg::TREE_LEAVES+i].vld = cand[i];
				nodes[tcpc_pkg::TREE_LEAVES+i].age = now - times[i];
				nodes[tcpc_pkg::TREE_LEAVES+i].t   = times[i];
			end else begin
				nodes[tcpc_pkg::TREE_LEAVES+i] = '0;
			end
		end
		// On equal ages the lower pad index wins.
		for (int i = tcpc_pkg::TREE_LEAVES - 1; i >= 1; i--) begin
			if (nodes[2*i+1].vld && (!nodes[2*i].vld || nodes[2*i+1].age < nodes[2*i].age)) begin
				nodes[i] = nodes[2*i+1];
			end else begin
				nodes[i] = nodes[2*i];
			end
		end
		latest = nodes[1].vld ? nodes[1].t : '0;
	end

endmodule

// ===== design/tcpc_core.sv =====
// ----------------------------------------------------------------------------
// Classifier core
// Holds the pad and combo state and the configuration registers, and turns
// one press or release into at most one touch or combo event.
// ----------------------------------------------------------------------------
module tcpc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  tcpc_pkg::cfg_wr_t cfg_wr,
	input  logic              fire,
	input  tcpc_pkg::item_t   item,
	output logic              res_vld,
	output tcpc_pkg::result_t res
);

	tcpc_pkg::cfg_t     cfg_q;
	tcpc_pkg::pad_vec_t act_q;
	tcpc_pkg::time_t    time_q [tcpc_pkg::NUM_PADS];
	logic               armed_q;
	logic               supp_q;
	tcpc_pkg::time_t    start_q;

	tcpc_pkg::pad_vec_t bit_v;
	tcpc_pkg::pad_vec_t mask_v;
	tcpc_pkg::pad_vec_t act_n;
	tcpc_pkg::time_t    times_n [tcpc_pkg::NUM_PADS];
	tcpc_pkg::time_t    latest;
	tcpc_pkg::time_t    combo_hold;
	tcpc_pkg::time_t    touch_hold;
	logic               is_press;
	logic               rel_ok;
	logic               all_old;
	logic               all_new;
	logic               any_new;
	logic               full;
	logic               armed_n;
	logic               supp_n;
	tcpc_pkg::time_t    start_n;

	always_comb begin
		mask_v     = cfg_q.combo_mask;
		bit_v      = tcpc_pkg::pad_vec_t'(1) << item.pad;
		is_press   = item.mode == tcpc_pkg::MODE_PRESS;
		rel_ok     = !is_press && ((act_q & bit_v) != '0);
		all_old    = (mask_v != '0) && ((act_q & mask_v) == mask_v);
		if (is_press) begin
			act_n = act_q | bit_v;
		end else if (rel_ok) begin
			act_n = act_q & ~bit_v;
		end else begin
			act_n = act_q;
		end
		for (int p = 0; p < tcpc_pkg::NUM_PADS; p++) begin
			times_n[p] = (is_press && item.pad == tcpc_pkg::pad_t'(p)) ? item.time_ms : time_q[p];
		end
		all_new    = (mask_v != '0) && ((act_n & mask_v) == mask_v);
		any_new    = (act_n & mask_v) != '0;
		full       = armed_q && all_old && mask_v[item.pad];
		combo_hold = item.time_ms - start_q;
		touch_hold = item.time_ms - time_q[item.pad];

		res_vld = 1'b0;
		res     = '0;
		if (rel_ok) begin
			if (full) begin
				res_vld        = combo_hold >= tcpc_pkg::time_t'(cfg_q.combo_emit_ms);
				res.event_kind = tcpc_pkg::EVENT_COMBO;
				res.hold_ms    = combo_hold;
			end else if (!supp_q) begin
				res_vld        = 1'b1;
				res.event_kind = tcpc_pkg::EVENT_TOUCH;
				res.pad_out    = item.pad;
				res.long_hold  = touch_hold >= tcpc_pkg::time_t'(cfg_q.long_hold_ms);
				res.hold_ms    = touch_hold;
			end
		end

		armed_n = armed_q;
		supp_n  = supp_q;
		start_n = start_q;
		if (is_press) begin
			if (!supp_q && all_new && !armed_q) begin
				armed_n = 1'b1;
				start_n = latest;
			end
		end else if (rel_ok) begin
			armed_n = all_new;
			if (full) begin
				supp_n = 1'b1;
			end
			if (all_new) begin
				start_n = latest;
			end else if (!any_new) begin
				supp_n  = 1'b0;
				start_n = '0;
			end
		end
	end

	tcpc_latest u_latest (
		.now    (item.time_ms),
		.cand   (act_n & mask_v),
		.times  (times_n),
		.latest (latest)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.combo_mask    <= '0;
			cfg_q.long_hold_ms  <= 16'd1000;
			cfg_q.combo_emit_ms <= 16'd500;
			act_q               <= '0;
			armed_q             <= 1'b0;
			supp_q              <= 1'b0;
			start_q             <= '0;
		end else begin
			if (cfg_wr.we) begin
				case (cfg_wr.index)
					tcpc_pkg::CFG_COMBO_MASK:    cfg_q.combo_mask <= cfg_wr.wdata[tcpc_pkg::NUM_PADS-1:0];
					tcpc_pkg::CFG_LONG_HOLD_MS:  cfg_q.long_hold_ms <= cfg_wr.wdata;
					tcpc_pkg::CFG_COMBO_EMIT_MS: cfg_q.combo_emit_ms <= cfg_wr.wdata;
					default: begin
					end
				endcase
			end
			if (fire) begin
				act_q   <= act_n;
				armed_q <= armed_n;
				supp_q  <= supp_n;
				start_q <= start_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_press) begin
			time_q[item.pad] <= item.time_ms;
		end
	end

endmodule

// ===== design/tcpc_out_stage.sv =====
// ----------------------------------------------------------------------------
// Result register
// Holds one classified event until the downstream side takes it.
// ----------------------------------------------------------------------------
module tcpc_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  tcpc_pkg::result_t res,
	output logic              free,
	tcpc_out_if.source        result
);

	logic              valid_q;
	tcpc_pkg::result_t res_q;

	assign free              = !valid_q || result.ready;
	assign result.valid      = valid_q;
	assign result.event_kind = res_q.event_kind;
	assign result.pad_out    = res_q.pad_out;
	assign result.long_hold  = res_q.long_hold;
	assign result.hold_ms    = res_q.hold_ms;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// ===== design/touch_combo_press_classifier.sv =====
// ----------------------------------------------------------------------------
// Touch combo press classifier
// Tracks pad presses and classifies releases into touch events with a
// hold time and long-press flag, or combo events when all combo pads were held long enough.
// ----------------------------------------------------------------------------
// Channel   Role  Payload
// touch     sink  mode, pad, time_ms
// result    src   event_kind, pad_out, long_hold, hold_ms
// cfg_*     in    write enable, register index, write data
//
// An accepted transaction waits in the input register until the result
// register is free; its event is then registered there for the result channel.
// One transaction can be taken every cycle while result does not stall; the
// pad state update and the eight-pad latest-press tree are combinational.
// Reset clears the active-pad and combo state and loads the default thresholds; press times are not reset.
// A stalled result register holds the input register, which then stalls touch.
module touch_combo_press_classifier (
	input  logic                                clk,
	input  logic                                arst_n,
	tcpc_in_if.sink                             touch,
	tcpc_out_if.source                          result,
	input  logic                                cfg_we,
	input  logic [tcpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [tcpc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	logic              valid_s1;
	tcpc_pkg::item_t   item_s1;
	logic              out_free;
	logic              fire;
	logic              res_vld;
	tcpc_pkg::result_t res;
	tcpc_pkg::cfg_wr_t cfg_wr;

	assign fire         = valid_s1 && out_free;
	assign cfg_wr.we    = cfg_we;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.wdata = cfg_wdata;

	tcpc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.touch    (touch),
		.take     (fire),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	tcpc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_wr  (cfg_wr),
		.fire    (fire),
		.item    (item_s1),
		.res_vld (res_vld),
		.res     (res)
	);

	tcpc_out_stage u_out_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire && res_vld),
		.res    (res),
		.free   (out_free),
		.result (result)
	);

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fire) |=> (valid_s1 && $stable(item_s1)))
		else $error("Input register changed while stalled.");

	a_press_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.mode == tcpc_pkg::MODE_PRESS) |-> !res_vld)
		else $error("A press produced an event.");

	a_combo_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_vld && res.event_kind == tcpc_pkg::EVENT_COMBO) |->
		(res.pad_out == '0 && !res.long_hold))
		else $error("Combo event carries pad or long-press bits.");

	a_load_delivered: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_vld) |=> result.valid)
		else $error("Loaded event is not presented.");

endmodule
